>>> rtl/bflp_pkg.sv
// Package for the longest-path core: sizes, codes, controller states and the
// command/status structs between controller and datapath. No dependencies.
package bflp_pkg;

  localparam int MAX_NODES  = 4096;
  localparam int MAX_EDGES  = 8192;
  localparam int SCORE_BITS = 48;

  localparam int NODE_W     = 13;                 // node number field, 1..MAX_NODES
  localparam int NODE_AW    = $clog2(MAX_NODES);  // node memory address
  localparam int EDGE_AW    = $clog2(MAX_EDGES);  // edge memory address
  localparam int PTR_W      = EDGE_AW + 1;        // holds MAX_EDGES itself
  localparam int WEIGHT_W   = 32;
  localparam int DIST_W     = 64;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 14;
  localparam int NCNT_W     = 13;
  localparam int ECNT_W     = 14;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EDGE_COUNT = 2'd1;

  // opcodes of an input beat
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_RUN  = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_FINITE    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_UNBOUNDED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNREACH   = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_INIT, S_EFETCH, S_NFETCH, S_EXEC,
    S_FRD, S_FCHK, S_TRD, S_DONE
  } ctl_state_t;

  typedef enum logic [1:0] {
    PH_RELAX, PH_BACK, PH_FWD
  } phase_t;

  typedef enum logic [3:0] {
    DP_NOP, DP_LOAD, DP_CLEAR, DP_INIT, DP_EFETCH, DP_NFETCH,
    DP_RELAX, DP_BACK, DP_FWD, DP_FRD, DP_FCHK, DP_TRD, DP_RESULT
  } dp_op_t;

  typedef struct packed {
    dp_op_t              op;
    logic [EDGE_AW-1:0]  edge_addr;
    logic [NODE_AW-1:0]  node_addr;
    logic [NODE_W-1:0]   n_eff;
    logic                mark;
    logic                clr_change;
  } dp_cmd_t;

  typedef struct packed {
    logic changed;
  } dp_sts_t;

  typedef struct packed {
    logic [NODE_W-1:0]   src;
    logic [NODE_W-1:0]   dst;
    logic [WEIGHT_W-1:0] weight;
  } edge_t;

  typedef struct packed {
    logic              valid;
    logic [DIST_W-1:0] dval;
  } dist_ent_t;

endpackage

>>> rtl/bflp_in_if.sv
// Input channel: valid/ready with one load or run beat.
// Depends on bflp_pkg.
interface bflp_in_if
  import bflp_pkg::*;
;
  logic                       valid;
  logic                       ready;
  logic                       opcode;
  logic [NODE_W-1:0]          from_node;
  logic [NODE_W-1:0]          to_node;
  logic signed [WEIGHT_W-1:0] weight;

  modport source (output valid, opcode, from_node, to_node, weight, input ready);
  modport sink   (input valid, opcode, from_node, to_node, weight, output ready);
endinterface

>>> rtl/bflp_out_if.sv
// Result channel: valid/ready with status and score.
// Depends on bflp_pkg.
interface bflp_out_if
  import bflp_pkg::*;
;
  logic                         valid;
  logic                         ready;
  logic [STATUS_W-1:0]          status;
  logic signed [SCORE_BITS-1:0] score;

  modport source (output valid, status, score, input ready);
  modport sink   (input valid, status, score, output ready);
endinterface

>>> rtl/bflp_cfg_if.sv
// Configuration write channel: valid/ready with register index and data.
// Depends on bflp_pkg.
interface bflp_cfg_if
  import bflp_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/bflp_datapath.sv
// Datapath: edge store, distance and flag memories, relaxation arithmetic,
// reachability updates and the result register. Depends on bflp_pkg.
module bflp_datapath
  import bflp_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  dp_cmd_t                      cmd,
  input  logic [NODE_W-1:0]            in_from_node,
  input  logic [NODE_W-1:0]            in_to_node,
  input  logic [WEIGHT_W-1:0]          in_weight,
  output dp_sts_t                      sts,
  output logic [STATUS_W-1:0]          out_status,
  output logic signed [SCORE_BITS-1:0] out_score
);

  localparam logic signed [DIST_W-1:0] SMAX = DIST_W'((64'sd1 <<< (SCORE_BITS - 1)) - 1);
  localparam logic signed [DIST_W-1:0] SMIN = -SMAX - DIST_W'(1);

  edge_t     edge_mem [MAX_EDGES];
  dist_ent_t dist_mem [MAX_NODES];
  logic      imp_mem  [MAX_NODES];
  logic      rt_mem   [MAX_NODES];
  logic      rf_mem   [MAX_NODES];

  edge_t     edge_r;
  dist_ent_t da_r, db_r;
  logic      rta_r, rtb_r, rfa_r, rfb_r, imp_r;
  logic      change_r, hit_r;
  logic [STATUS_W-1:0]   status_r;
  logic [SCORE_BITS-1:0] score_r;

  logic [NODE_W-1:0]  nm1;
  logic [NODE_AW-1:0] src_a, dst_a, rd_a, rd_b;
  logic               in_rng;
  logic signed [DIST_W-1:0] wext, cand, neg;
  logic               relax_ok, back_set, fwd_set, set_now;
  logic               dist_we, imp_we, rt_we, rf_we, flag_d;
  logic [NODE_AW-1:0] dist_wa, imp_wa, rt_wa, rf_wa;
  dist_ent_t          dist_wd;

  // decode the current edge
  always_comb begin
    nm1    = cmd.n_eff - NODE_W'(1);
    src_a  = NODE_AW'(edge_r.src - NODE_W'(1));
    dst_a  = NODE_AW'(edge_r.dst - NODE_W'(1));
    in_rng = (edge_r.src != '0) && (edge_r.src <= cmd.n_eff) &&
             (edge_r.dst != '0) && (edge_r.dst <= cmd.n_eff);
    wext   = {{(DIST_W-WEIGHT_W){edge_r.weight[WEIGHT_W-1]}}, edge_r.weight};
    cand   = $signed(da_r.dval) - wext;
    relax_ok = in_rng && da_r.valid &&
               (!db_r.valid || (cand < $signed(db_r.dval)));
    back_set = in_rng && rtb_r && !rta_r;
    fwd_set  = in_rng && rfa_r && !rfb_r;
    set_now  = ((cmd.op == DP_BACK) && back_set) || ((cmd.op == DP_FWD) && fwd_set);
    rd_a     = (cmd.op == DP_FRD) ? cmd.node_addr : src_a;
    rd_b     = (cmd.op == DP_TRD) ? NODE_AW'(nm1) : dst_a;
    neg      = -$signed(db_r.dval);
  end

  // write port selection
  always_comb begin
    dist_we = 1'b0; imp_we = 1'b0; rt_we = 1'b0; rf_we = 1'b0;
    dist_wa = dst_a; imp_wa = dst_a; rt_wa = src_a; rf_wa = dst_a;
    dist_wd = '{valid: 1'b1, dval: cand};
    flag_d  = (cmd.op != DP_CLEAR);
    unique case (cmd.op)
      DP_CLEAR: begin
        dist_we = 1'b1; imp_we = 1'b1; rt_we = 1'b1; rf_we = 1'b1;
        dist_wa = cmd.node_addr; imp_wa = cmd.node_addr;
        rt_wa   = cmd.node_addr; rf_wa  = cmd.node_addr;
        dist_wd = '0;
      end
      DP_INIT: begin
        dist_we = 1'b1; rt_we = 1'b1; rf_we = 1'b1;
        dist_wa = '0; rf_wa = '0; rt_wa = NODE_AW'(nm1);
        dist_wd = '{valid: 1'b1, dval: '0};
      end
      DP_RELAX: begin
        dist_we = relax_ok;
        imp_we  = relax_ok && cmd.mark;
      end
      DP_BACK: rt_we = back_set;
      DP_FWD:  rf_we = fwd_set;
      default: ;
    endcase
  end

  // edge store: write on load, registered read on fetch
  always_ff @(posedge clk) begin
    if (cmd.op == DP_LOAD) begin
      edge_mem[cmd.edge_addr] <= '{src: in_from_node, dst: in_to_node, weight: in_weight};
    end
    if (cmd.op == DP_EFETCH) begin
      edge_r <= edge_mem[cmd.edge_addr];
    end
  end

  // distance memory: one write, two registered reads
  always_ff @(posedge clk) begin
    if (dist_we) begin
      dist_mem[dist_wa] <= dist_wd;
    end
    if (cmd.op == DP_NFETCH || cmd.op == DP_TRD) begin
      da_r <= dist_mem[rd_a];
      db_r <= dist_mem[rd_b];
    end
  end

  // flag memories
  always_ff @(posedge clk) begin
    if (imp_we) begin
      imp_mem[imp_wa] <= flag_d;
    end
    if (rt_we) begin
      rt_mem[rt_wa] <= flag_d;
    end
    if (rf_we) begin
      rf_mem[rf_wa] <= flag_d;
    end
    if (cmd.op == DP_NFETCH || cmd.op == DP_FRD) begin
      rta_r <= rt_mem[rd_a];
      rtb_r <= rt_mem[rd_b];
      rfa_r <= rf_mem[rd_a];
      rfb_r <= rf_mem[rd_b];
      imp_r <= imp_mem[rd_a];
    end
  end

  // sticky change and cycle flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      change_r <= 1'b0;
      hit_r    <= 1'b0;
    end else begin
      change_r <= cmd.clr_change ? 1'b0 : (change_r | set_now);
      if (cmd.op == DP_INIT) begin
        hit_r <= 1'b0;
      end else if (cmd.op == DP_FCHK && imp_r && rta_r && rfa_r) begin
        hit_r <= 1'b1;
      end
    end
  end

  // result payload, saturated to the score width
  always_ff @(posedge clk) begin
    if (cmd.op == DP_RESULT) begin
      priority if (hit_r) begin
        status_r <= ST_UNBOUNDED;
        score_r  <= '0;
      end else if (!db_r.valid) begin
        status_r <= ST_UNREACH;
        score_r  <= '0;
      end else begin
        status_r <= ST_FINITE;
        priority if (neg > SMAX)      score_r <= SCORE_BITS'(SMAX);
        else if (neg < SMIN)          score_r <= SCORE_BITS'(SMIN);
        else                          score_r <= SCORE_BITS'(neg);
      end
    end
  end

  assign sts.changed = change_r | set_now;
  assign out_status  = status_r;
  assign out_score   = $signed(score_r);

endmodule

>>> rtl/bflp_ctrl.sv
// Controller: configuration registers, load pointer, scan counters and the
// run sequencer that commands the datapath. Depends on bflp_pkg.
module bflp_ctrl
  import bflp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_opcode,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  cfg_ready,
  output dp_cmd_t               cmd,
  input  dp_sts_t               sts
);

  ctl_state_t state_r, state_nxt;
  phase_t     phase_r, phase_nxt;
  logic [NCNT_W-1:0]  node_count_r;
  logic [ECNT_W-1:0]  edge_count_r;
  logic [PTR_W-1:0]   load_ptr_r, load_ptr_nxt;
  logic [EDGE_AW-1:0] eidx_r, eidx_nxt;
  logic [NODE_AW-1:0] naddr_r, naddr_nxt;
  logic [NODE_AW-1:0] pass_r, pass_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic [NODE_W-1:0]  n_eff, nm1;
  logic [ECNT_W-1:0]  m_eff;
  logic               in_acc, last_edge, last_pass, out_free;

  // clamp configuration
  always_comb begin
    if (node_count_r < NCNT_W'(2))              n_eff = NODE_W'(2);
    else if (node_count_r > NCNT_W'(MAX_NODES)) n_eff = NODE_W'(MAX_NODES);
    else                                        n_eff = node_count_r;
    m_eff     = (edge_count_r > ECNT_W'(MAX_EDGES)) ? ECNT_W'(MAX_EDGES) : edge_count_r;
    nm1       = n_eff - NODE_W'(1);
    in_acc    = in_valid && in_ready;
    last_edge = (ECNT_W'(eidx_r) + ECNT_W'(1)) == m_eff;
    last_pass = NODE_W'(pass_r) == nm1;
    out_free  = !out_valid_r || out_ready;
  end

  // next state and counters
  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    load_ptr_nxt  = load_ptr_r;
    eidx_nxt      = eidx_r;
    naddr_nxt     = naddr_r;
    pass_nxt      = pass_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_opcode == OP_RUN) begin
            state_nxt = S_CLEAR;
            naddr_nxt = '0;
          end else if (load_ptr_r < PTR_W'(MAX_EDGES)) begin
            load_ptr_nxt = load_ptr_r + PTR_W'(1);
          end
        end
      end
      S_CLEAR: begin
        naddr_nxt = naddr_r + NODE_AW'(1);
        if (naddr_r == NODE_AW'(MAX_NODES - 1)) state_nxt = S_INIT;
      end
      S_INIT: begin
        phase_nxt = PH_RELAX;
        pass_nxt  = '0;
        eidx_nxt  = '0;
        naddr_nxt = '0;
        state_nxt = (m_eff == '0) ? S_FRD : S_EFETCH;
      end
      S_EFETCH: state_nxt = S_NFETCH;
      S_NFETCH: state_nxt = S_EXEC;
      S_EXEC: begin
        eidx_nxt  = eidx_r + EDGE_AW'(1);
        state_nxt = S_EFETCH;
        if (last_edge) begin
          eidx_nxt = '0;
          unique case (phase_r)
            PH_RELAX: begin
              if (last_pass) phase_nxt = PH_BACK;
              else           pass_nxt  = pass_r + NODE_AW'(1);
            end
            PH_BACK: begin
              if (!sts.changed) phase_nxt = PH_FWD;
            end
            PH_FWD: begin
              if (!sts.changed) begin
                state_nxt = S_FRD;
                naddr_nxt = '0;
              end
            end
            default: ;
          endcase
        end
      end
      S_FRD: state_nxt = S_FCHK;
      S_FCHK: begin
        naddr_nxt = naddr_r + NODE_AW'(1);
        if (NODE_W'(naddr_r) == nm1) state_nxt = S_TRD;
        else                         state_nxt = S_FRD;
      end
      S_TRD: state_nxt = S_DONE;
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          load_ptr_nxt  = '0;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath commands and handshake outputs
  always_comb begin
    cmd            = '0;
    cmd.op         = DP_NOP;
    cmd.edge_addr  = eidx_r;
    cmd.node_addr  = naddr_r;
    cmd.n_eff      = n_eff;
    cmd.mark       = last_pass;
    cmd.clr_change = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        cmd.edge_addr = EDGE_AW'(load_ptr_r);
        if (in_acc && in_opcode == OP_LOAD && load_ptr_r < PTR_W'(MAX_EDGES)) begin
          cmd.op = DP_LOAD;
        end
      end
      S_CLEAR:  cmd.op = DP_CLEAR;
      S_INIT: begin
        cmd.op         = DP_INIT;
        cmd.clr_change = 1'b1;
      end
      S_EFETCH: cmd.op = DP_EFETCH;
      S_NFETCH: cmd.op = DP_NFETCH;
      S_EXEC: begin
        unique case (phase_r)
          PH_RELAX: cmd.op = DP_RELAX;
          PH_BACK:  cmd.op = DP_BACK;
          PH_FWD:   cmd.op = DP_FWD;
          default:  cmd.op = DP_NOP;
        endcase
        cmd.clr_change = last_edge;
      end
      S_FRD:    cmd.op = DP_FRD;
      S_FCHK:   cmd.op = DP_FCHK;
      S_TRD:    cmd.op = DP_TRD;
      S_DONE:   cmd.op = out_free ? DP_RESULT : DP_NOP;
      default:  cmd.op = DP_NOP;
    endcase
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign cfg_ready = 1'b1;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      phase_r      <= PH_RELAX;
      load_ptr_r   <= '0;
      eidx_r       <= '0;
      naddr_r      <= '0;
      pass_r       <= '0;
      out_valid_r  <= 1'b0;
      node_count_r <= NCNT_W'(2);
      edge_count_r <= ECNT_W'(1);
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      load_ptr_r  <= load_ptr_nxt;
      eidx_r      <= eidx_nxt;
      naddr_r     <= naddr_nxt;
      pass_r      <= pass_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_NODE_COUNT) node_count_r <= cfg_data[NCNT_W-1:0];
        if (cfg_index == CFG_EDGE_COUNT) edge_count_r <= cfg_data[ECNT_W-1:0];
      end
    end
  end

endmodule

>>> rtl/bellman_ford_longest_path_core.sv
// Longest path core. A run makes a clearing pass over the node memories,
// then steps through each edge visit in edge fetch, node fetch and execute
// states, as the distance memory reads need the registered edge read first.
// One result per run; a run waits only if the previous result is untaken.
// rst_n is synchronous: node_count 2, edge_count 1, load pointer zero.
module bellman_ford_longest_path_core
  import bflp_pkg::*;
(
  input logic   clk,
  input logic   rst_n,
  bflp_in_if.sink     in_ch,
  bflp_out_if.source  out_ch,
  bflp_cfg_if.sink    cfg_ch
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencer
  bflp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_opcode (in_ch.opcode),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cfg_valid (cfg_ch.valid),
    .cfg_index (cfg_ch.index),
    .cfg_data  (cfg_ch.data),
    .cfg_ready (cfg_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // memories and arithmetic
  bflp_datapath u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .in_from_node (in_ch.from_node),
    .in_to_node   (in_ch.to_node),
    .in_weight    (in_ch.weight),
    .sts          (sts),
    .out_status   (out_ch.status),
    .out_score    (out_ch.score)
  );

endmodule

>>> tb/tb_bellman_ford_longest_path_core.sv
// Testbench for the longest-path core: loads random and directed edge lists,
// runs them and checks each status/score against a predictor in a scoreboard.
// Depends on bflp_pkg, the three channel interfaces and the core itself.
module tb_bellman_ford_longest_path_core
  import bflp_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 1500000;
  localparam int SETTLE_CYC     = 32;
  localparam int HOLD_CYC       = 20000;
  localparam int RANDOM_BEATS   = 1100;

  // register indexes that name no register
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  typedef struct {
    logic [STATUS_W-1:0]          status;
    logic signed [SCORE_BITS-1:0] score;
  } path_result_t;

  // Scoreboard: predicts each run from its own copy of the edge store
  class path_scoreboard;
    logic [NODE_W-1:0] e_src [MAX_EDGES];
    logic [NODE_W-1:0] e_dst [MAX_EDGES];
    longint            e_wt  [MAX_EDGES];
    longint            dist_v   [0:MAX_NODES];
    bit                dist_ok  [0:MAX_NODES];
    bit                improved [0:MAX_NODES];
    bit                to_tgt   [0:MAX_NODES];
    bit                from_st  [0:MAX_NODES];
    int unsigned       load_ptr;
    int unsigned       written_hi;
    int unsigned       node_reg;
    int unsigned       edge_reg;
    path_result_t      expected_q[$];
    int                errors;
    int                runs;
    int                by_status[3];

    function new();
      load_ptr   = 0;
      written_hi = 0;
      node_reg   = 2;
      edge_reg   = 1;
      errors     = 0;
      runs       = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    task report(input string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    function void note_config(input logic [CFG_IDX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_NODE_COUNT) node_reg = data[NCNT_W-1:0];
      else if (idx == CFG_EDGE_COUNT) edge_reg = data;
    endfunction

    // one relaxation pass on negated weights, optionally marking improvers
    function void relax_pass(int unsigned n, int unsigned m, bit mark);
      int unsigned u;
      int unsigned v;
      longint cand;
      for (int unsigned i = 0; i < m; i++) begin
        u = e_src[i];
        v = e_dst[i];
        if (u == 0 || u > n || v == 0 || v > n || !dist_ok[u]) continue;
        cand = dist_v[u] - e_wt[i];
        if (!dist_ok[v] || cand < dist_v[v]) begin
          dist_v[v] = cand;
          dist_ok[v] = 1'b1;
          if (mark) improved[v] = 1'b1;
        end
      end
    endfunction

    // reachability fixpoint by repeated edge scans
    function void sweep(int unsigned n, int unsigned m, bit backward);
      bit changed;
      int unsigned u;
      int unsigned v;
      changed = 1'b1;
      while (changed) begin
        changed = 1'b0;
        for (int unsigned i = 0; i < m; i++) begin
          u = e_src[i];
          v = e_dst[i];
          if (u == 0 || u > n || v == 0 || v > n) continue;
          if (backward) begin
            if (to_tgt[v] && !to_tgt[u]) begin
              to_tgt[u] = 1'b1;
              changed = 1'b1;
            end
          end else if (from_st[u] && !from_st[v]) begin
            from_st[v] = 1'b1;
            changed = 1'b1;
          end
        end
      end
    endfunction

    function void predict_run();
      int unsigned n;
      int unsigned m;
      longint score;
      longint smax;
      path_result_t r;
      smax = (longint'(1) <<< (SCORE_BITS - 1)) - 1;
      n = node_reg;
      if (n < 2) n = 2;
      if (n > MAX_NODES) n = MAX_NODES;
      m = edge_reg;
      if (m > MAX_EDGES) m = MAX_EDGES;
      for (int k = 0; k <= MAX_NODES; k++) begin
        dist_ok[k]  = 1'b0;
        improved[k] = 1'b0;
        to_tgt[k]   = 1'b0;
        from_st[k]  = 1'b0;
      end
      dist_v[1] = 0;
      dist_ok[1] = 1'b1;
      for (int unsigned p = 1; p < n; p++) relax_pass(n, m, 1'b0);
      relax_pass(n, m, 1'b1);
      to_tgt[n] = 1'b1;
      sweep(n, m, 1'b1);
      from_st[1] = 1'b1;
      sweep(n, m, 1'b0);
      r.status = ST_FINITE;
      r.score  = '0;
      for (int unsigned k = 1; k <= n; k++) begin
        if (improved[k] && to_tgt[k] && from_st[k]) begin
          r.status = ST_UNBOUNDED;
          break;
        end
      end
      if (r.status == ST_FINITE) begin
        if (!dist_ok[n]) begin
          r.status = ST_UNREACH;
        end else begin
          score = -dist_v[n];
          if (score > smax) score = smax;
          if (score < -smax - 1) score = -smax - 1;
          r.score = score[SCORE_BITS-1:0];
        end
      end
      load_ptr = 0;
      expected_q.insert(expected_q.size(), r);
    endfunction

    function void note_beat(input logic op, input logic [NODE_W-1:0] from_n,
                            input logic [NODE_W-1:0] to_n,
                            input logic signed [WEIGHT_W-1:0] w);
      if (op == OP_RUN) begin
        predict_run();
      end else if (load_ptr < MAX_EDGES) begin
        e_src[load_ptr] = from_n;
        e_dst[load_ptr] = to_n;
        e_wt[load_ptr]  = longint'(w);
        load_ptr++;
        if (load_ptr > written_hi) written_hi = load_ptr;
      end
    endfunction

    task check_result(input logic [STATUS_W-1:0] status,
                      input logic signed [SCORE_BITS-1:0] score);
      path_result_t exp_r;
      if (expected_q.size() == 0) begin
        report($sformatf("result status %0d score %0d with none expected",
                         status, score));
      end else begin
        exp_r = expected_q.pop_front();
        runs++;
        if (exp_r.status < 3) by_status[exp_r.status]++;
        if (status !== exp_r.status)
          report($sformatf("run %0d status %0d, expected %0d", runs, status,
                           exp_r.status));
        if (score !== exp_r.score)
          report($sformatf("run %0d score %0d, expected %0d", runs, score,
                           exp_r.score));
      end
    endtask
  endclass

  logic clk;
  logic rst_n;

  bflp_in_if  in_ch();
  bflp_out_if out_ch();
  bflp_cfg_if cfg_ch();

  bellman_ford_longest_path_core i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg_ch (cfg_ch.sink)
  );

  path_scoreboard sb;
  int send_idle;
  int recv_idle;
  bit hold_req;
  int beats_sent;
  int stall_cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // observe every handshake at the clock edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        sb.note_beat(in_ch.opcode, in_ch.from_node, in_ch.to_node, in_ch.weight);
      if (cfg_ch.valid && cfg_ch.ready) sb.note_config(cfg_ch.index, cfg_ch.data);
      if (out_ch.valid && out_ch.ready) sb.check_result(out_ch.status, out_ch.score);
    end
  end

  // watchdog: end the run after too long without any beat
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", stall_cycles);
      $display("TB_ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // result receiver: random stalls, plus a long hold-off on request
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYC) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  task automatic send_beat(input logic op, input logic [NODE_W-1:0] from_n,
                           input logic [NODE_W-1:0] to_n, input logic [31:0] w);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.opcode    <= op;
    in_ch.from_node <= from_n;
    in_ch.to_node   <= to_n;
    in_ch.weight    <= w;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic load_edge(input int from_n, input int to_n, input logic [31:0] w);
    send_beat(OP_LOAD, NODE_W'(from_n), NODE_W'(to_n), w);
  endtask

  task automatic start_run();
    send_beat(OP_RUN, NODE_W'($urandom_range(8191)), NODE_W'($urandom_range(8191)),
              $urandom);
  endtask

  // hold the input idle until every result is in and the core has gone quiet
  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data[CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_graph_size(input int n, input int m);
    settle();
    cfg_write(CFG_NODE_COUNT, n);
    cfg_write(CFG_EDGE_COUNT, m);
  endtask

  function automatic logic [31:0] pick_weight(input int mode);
    case (mode)
      0: return -$urandom_range(0, 50);
      1: return $urandom_range(0, 60) - 30;
      default: return $urandom;
    endcase
  endfunction

  function automatic int pick_node(input int n);
    if ($urandom_range(99) < 90) return $urandom_range(1, n);
    return $urandom_range(0, 8191);
  endfunction

  // one random graph: size it, load it and run it
  task automatic random_graph();
    int n;
    int n_raw;
    int m;
    int loads;
    int mode;
    int sel;
    int m_hi;
    sel = $urandom_range(99);
    if (sel < 88) n = $urandom_range(2, 8);
    else if (sel < 98) n = $urandom_range(9, 40);
    else n = $urandom_range(4090, 4096);
    n_raw = n;
    if ($urandom_range(99) < 3) n_raw = $urandom_range(0, 1);
    if (n_raw < 2) n = 2;
    mode = $urandom_range(0, 9) < 5 ? 0 : ($urandom_range(0, 9) < 7 ? 1 : 2);
    loads = (n > 40) ? $urandom_range(1, 3) : $urandom_range(1, 16);
    m = loads;
    sel = $urandom_range(99);
    if (sel < 10) begin
      // reuse only edges that earlier graphs left in the store
      loads = 0;
      m_hi  = (sb.written_hi < 6) ? int'(sb.written_hi) : 6;
      m     = $urandom_range(0, m_hi);
    end else if (sel < 20) begin
      m = $urandom_range(0, loads);
    end
    set_graph_size(n_raw, m);
    for (int i = 0; i < loads; i++) begin
      load_edge(pick_node(n), pick_node(n), pick_weight(mode));
      beats_sent++;
    end
    start_run();
    beats_sent++;
  endtask

  initial begin
    sb = new();
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.opcode    <= OP_LOAD;
    in_ch.from_node <= '0;
    in_ch.to_node   <= '0;
    in_ch.weight    <= '0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.index    <= '0;
    cfg_ch.data     <= '0;
    stall_cycles    <= 0;
    hold_req   = 1'b0;
    beats_sent = 0;
    send_idle  = 19;
    recv_idle  = 67;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset sizes, one plain edge
    load_edge(1, 2, 5);
    start_run();
    // weight extremes along a chain, and an edge from node zero
    set_graph_size(3, 3);
    load_edge(1, 2, 32'h8000_0000);
    load_edge(2, 3, 32'h7fff_ffff);
    load_edge(0, 3, 7);
    start_run();
    // positive cycle off the target path, target unreachable
    set_graph_size(3, 2);
    load_edge(1, 2, 4);
    load_edge(2, 1, 1);
    start_run();
    // the same cycle now leads to the target
    set_graph_size(3, 3);
    load_edge(1, 2, 4);
    load_edge(2, 1, 1);
    load_edge(2, 3, -3);
    start_run();
    // node count below range, no edges at all
    set_graph_size(0, 0);
    start_run();
    // node count above range clamps; an edge from beyond the graph
    set_graph_size(8191, 2);
    load_edge(1, 4096, 9);
    load_edge(8191, 4096, 1);
    start_run();
    // writes to indexes beyond the register set do nothing
    settle();
    cfg_write(CFG_SPARE_A, 16383);
    cfg_write(CFG_SPARE_B, 0);
    set_graph_size(1, 1);
    load_edge(1, 2, 32'hffff_ffff);
    start_run();

    // back-pressure: the receiver stops while runs keep coming
    set_graph_size(3, 2);
    hold_req = 1'b1;
    for (int r = 0; r < 3; r++) begin
      load_edge(1, 2, $urandom_range(0, 100));
      load_edge(2, 3, $urandom_range(0, 100));
      start_run();
    end

    // random graphs in three idling phases
    while (beats_sent < RANDOM_BEATS) begin
      if (beats_sent < RANDOM_BEATS / 3) begin
        send_idle = 19;
        recv_idle = 67;
      end else if (beats_sent < 2 * RANDOM_BEATS / 3) begin
        send_idle = 67;
        recv_idle = 19;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      random_graph();
    end

    settle();
    $display("checked %0d runs: %0d finite, %0d unbounded, %0d unreachable",
             sb.runs, sb.by_status[0], sb.by_status[1], sb.by_status[2]);
    $display("random beats %0d, plus directed corner and back-pressure runs",
             beats_sent);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
